[rtl/hpg_pkg.sv]
// hpg_pkg: shared types, prime and reciprocal tables for the halton point generator
// no dependencies; imported by hpg_ctrl, the top level and hpg_props

package hpg_pkg;

  localparam int NUM_PRIMES = 23;
  localparam int PRIME_W    = 7;
  localparam int RECIP_W    = 30;
  localparam int SHIFT_W    = 6;
  localparam int PIDX_W     = 5;
  localparam int DIM_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SET = 1'd1;

  localparam logic [PRIME_W-1:0] PRIMES [NUM_PRIMES] = '{
    7'd2,  7'd3,  7'd5,  7'd7,  7'd11, 7'd13, 7'd17, 7'd19, 7'd23, 7'd29, 7'd31, 7'd37,
    7'd41, 7'd43, 7'd47, 7'd53, 7'd59, 7'd61, 7'd67, 7'd71, 7'd73, 7'd79, 7'd83
  };

  // floor(m / b) == (m * RECIPS[i]) >> SHIFTS[i] for every m below 2^29
  localparam logic [SHIFT_W-1:0] SHIFTS [NUM_PRIMES] = '{
    6'd30, 6'd31, 6'd32, 6'd32, 6'd33, 6'd33, 6'd34, 6'd34, 6'd34, 6'd34, 6'd34, 6'd35,
    6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd36, 6'd36, 6'd36, 6'd36, 6'd36
  };

  localparam logic [RECIP_W-1:0] RECIPS [NUM_PRIMES] = '{
    30'(((64'd1 << 30) + 64'd1)  / 64'd2),
    30'(((64'd1 << 31) + 64'd2)  / 64'd3),
    30'(((64'd1 << 32) + 64'd4)  / 64'd5),
    30'(((64'd1 << 32) + 64'd6)  / 64'd7),
    30'(((64'd1 << 33) + 64'd10) / 64'd11),
    30'(((64'd1 << 33) + 64'd12) / 64'd13),
    30'(((64'd1 << 34) + 64'd16) / 64'd17),
    30'(((64'd1 << 34) + 64'd18) / 64'd19),
    30'(((64'd1 << 34) + 64'd22) / 64'd23),
    30'(((64'd1 << 34) + 64'd28) / 64'd29),
    30'(((64'd1 << 34) + 64'd30) / 64'd31),
    30'(((64'd1 << 35) + 64'd36) / 64'd37),
    30'(((64'd1 << 35) + 64'd40) / 64'd41),
    30'(((64'd1 << 35) + 64'd42) / 64'd43),
    30'(((64'd1 << 35) + 64'd46) / 64'd47),
    30'(((64'd1 << 35) + 64'd52) / 64'd53),
    30'(((64'd1 << 35) + 64'd58) / 64'd59),
    30'(((64'd1 << 35) + 64'd60) / 64'd61),
    30'(((64'd1 << 36) + 64'd66) / 64'd67),
    30'(((64'd1 << 36) + 64'd70) / 64'd71),
    30'(((64'd1 << 36) + 64'd72) / 64'd73),
    30'(((64'd1 << 36) + 64'd78) / 64'd79),
    30'(((64'd1 << 36) + 64'd82) / 64'd83)
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RECIP,
    ST_QB,
    ST_REV,
    ST_SCALE,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic in_valid;
    logic m_zero;
    logic div_last;
    logic slot_free;
    logic last_dim;
  } stat_t;

  typedef struct packed {
    logic in_ready;
    logic load_item;
    logic do_recip;
    logic do_qb;
    logic do_rev;
    logic do_scale;
    logic do_div;
    logic emit;
    logic next_dim;
  } ctrl_t;

endpackage

[rtl/hpg_mac.sv]
// hpg_mac: shared multiply-add unit, y = a * k + c
// depends on nothing; the caller registers the result

module hpg_mac #(
  parameter int A_W = 31,
  parameter int K_W = 30
) (
  input  logic [A_W-1:0]     a,
  input  logic [K_W-1:0]     k,
  input  logic [A_W-1:0]     c,
  output logic [A_W+K_W-1:0] y
);

  localparam int Y_W = A_W + K_W;

  assign y = Y_W'(a) * Y_W'(k) + Y_W'(c);

endmodule

[rtl/hpg_ctrl.sv]
// hpg_ctrl: sequencer for digit extraction, fraction division and result hand-off
// depends on hpg_pkg (state_t, stat_t, ctrl_t)

module hpg_ctrl import hpg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (stat.in_valid) state_next = ST_RECIP;
      end
      ST_RECIP: state_next = ST_QB;
      ST_QB:    state_next = ST_REV;
      ST_REV:   state_next = ST_SCALE;
      ST_SCALE: begin
        state_next = stat.m_zero ? ST_DIV : ST_RECIP;
      end
      ST_DIV: begin
        if (stat.div_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.slot_free) state_next = stat.last_dim ? ST_IDLE : ST_RECIP;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state)
      ST_IDLE: begin
        ctrl.in_ready  = 1'b1;
        ctrl.load_item = stat.in_valid;
      end
      ST_RECIP: ctrl.do_recip = 1'b1;
      ST_QB:    ctrl.do_qb    = 1'b1;
      ST_REV:   ctrl.do_rev   = 1'b1;
      ST_SCALE: ctrl.do_scale = 1'b1;
      ST_DIV:   ctrl.do_div   = 1'b1;
      ST_EMIT: begin
        ctrl.emit     = stat.slot_free;
        ctrl.next_dim = stat.slot_free & ~stat.last_dim;
      end
      default: ctrl = '0;
    endcase
  end

endmodule

[rtl/halton_point_generator_top.sv]
// sequence: per coordinate, the RECIP, QB, REV and SCALE steps for each base-b digit of n+1,
// then one DIV step per fraction bit of the COORD_BITS-bit coordinate and an EMIT hand-off
// step
// throughput: one point at a time, set by the single shared multiply-add unit and the 1-bit
// restoring division loop; the next point is taken once the last coordinate sits in the output
// reset: synchronous, clears the sequencer and output valid, num_dims to 1 and base_set to 0
// halton_point_generator_top: datapath registers around hpg_mac and hpg_ctrl; uses hpg_pkg

module halton_point_generator_top import hpg_pkg::*; #(
  parameter int INDEX_BITS = 24,
  parameter int MAX_DIMS   = 22,
  parameter int COORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [INDEX_BITS-1:0] point_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] coordinate,
  output logic [DIM_W-1:0]      dim_index,
  output logic                  last
);

  localparam int IDX_W   = INDEX_BITS + 1;
  localparam int SCALE_W = INDEX_BITS + PRIME_W;
  localparam int PROD_W  = SCALE_W + RECIP_W;
  localparam int CNT_W   = $clog2(COORD_BITS);

  logic [DIM_W-1:0]      num_dims;
  logic                  base_set;

  logic [IDX_W-1:0]      m0, m, q;
  logic [PROD_W-1:0]     acc;
  logic [SCALE_W-1:0]    rev, scale;
  logic [COORD_BITS-1:0] coord;
  logic [DIM_W-1:0]      dim, dim_last;
  logic [PIDX_W-1:0]     pidx;
  logic [CNT_W-1:0]      div_cnt;

  logic [IDX_W-1:0]      m_in, q_calc, digit;
  logic [DIM_W-1:0]      dims_eff;
  logic [PRIME_W-1:0]    prime_b;
  logic [RECIP_W-1:0]    recip;
  logic [SHIFT_W-1:0]    shift_amt;
  logic [SCALE_W-1:0]    mac_a, mac_c;
  logic [RECIP_W-1:0]    mac_k;
  logic [PROD_W-1:0]     mac_y;
  logic [SCALE_W:0]      div_t, div_diff;
  logic                  div_ge;

  stat_t stat;
  ctrl_t ctrl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims <= DIM_W'(1);
      base_set <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_DIMS: num_dims <= cfg_data;
        REG_BASE_SET: base_set <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_dims == '0) begin
      dims_eff = DIM_W'(1);
    end else if (num_dims > DIM_W'(MAX_DIMS)) begin
      dims_eff = DIM_W'(MAX_DIMS);
    end else begin
      dims_eff = num_dims;
    end
  end

  assign m_in      = IDX_W'(point_index) + IDX_W'(1);
  assign prime_b   = PRIMES[pidx];
  assign recip     = RECIPS[pidx];
  assign shift_amt = SHIFTS[pidx];
  assign q_calc    = IDX_W'(acc >> shift_amt);
  // acc holds q*b here, never above m
  assign digit     = m - IDX_W'(acc);

  always_comb begin
    mac_a = SCALE_W'(m);
    mac_k = recip;
    mac_c = '0;
    if (ctrl.do_qb) begin
      mac_a = SCALE_W'(q_calc);
      mac_k = RECIP_W'(prime_b);
    end else if (ctrl.do_rev) begin
      mac_a = rev;
      mac_k = RECIP_W'(prime_b);
      mac_c = SCALE_W'(digit);
    end else if (ctrl.do_scale) begin
      mac_a = scale;
      mac_k = RECIP_W'(prime_b);
    end
  end

  hpg_mac #(
    .A_W(SCALE_W),
    .K_W(RECIP_W)
  ) u_mac (
    .a(mac_a),
    .k(mac_k),
    .c(mac_c),
    .y(mac_y)
  );

  // restoring division of rev by scale, one fraction bit per cycle; rev holds the remainder
  assign div_t    = {rev, 1'b0};
  assign div_ge   = div_t >= {1'b0, scale};
  assign div_diff = div_t - {1'b0, scale};

  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      m0       <= m_in;
      m        <= m_in;
      rev      <= '0;
      scale    <= SCALE_W'(1);
      dim      <= '0;
      pidx     <= PIDX_W'(base_set);
      dim_last <= dims_eff - DIM_W'(1);
    end else if (ctrl.next_dim) begin
      m     <= m0;
      rev   <= '0;
      scale <= SCALE_W'(1);
      dim   <= dim + DIM_W'(1);
      pidx  <= pidx + PIDX_W'(1);
    end else begin
      if (ctrl.do_recip) acc <= mac_y;
      if (ctrl.do_qb) begin
        acc <= mac_y;
        q   <= q_calc;
      end
      if (ctrl.do_rev) begin
        rev <= SCALE_W'(mac_y);
        m   <= q;
      end
      if (ctrl.do_scale) begin
        scale   <= SCALE_W'(mac_y);
        div_cnt <= '0;
      end
      if (ctrl.do_div) begin
        rev     <= div_ge ? SCALE_W'(div_diff) : SCALE_W'(div_t);
        coord   <= {coord[COORD_BITS-2:0], div_ge};
        div_cnt <= div_cnt + CNT_W'(1);
      end
    end
  end

  assign stat.in_valid  = in_valid;
  assign stat.m_zero    = (m == '0);
  assign stat.div_last  = (div_cnt == CNT_W'(COORD_BITS - 1));
  assign stat.slot_free = ~out_valid | out_ready;
  assign stat.last_dim  = (dim == dim_last);

  hpg_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .stat(stat),
    .ctrl(ctrl)
  );

  assign in_ready = ctrl.in_ready;

  // output register lets the sequencer go on while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      coordinate <= coord;
      dim_index  <= dim;
      last       <= stat.last_dim;
    end
  end

endmodule

[rtl/hpg_checker.sv]
// hpg_props: port-level checks of the halton point generator, bound to the top level
// depends on hpg_pkg for field widths

module hpg_props import hpg_pkg::*; #(
  parameter int INDEX_BITS = 24,
  parameter int COORD_BITS = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [INDEX_BITS-1:0] point_index,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] coordinate,
  input logic [DIM_W-1:0]      dim_index,
  input logic                  last
);

  // reset leaves the block idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(point_index))
    else $error("offered item changed before it was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coordinate) &&
      $stable(dim_index) && $stable(last))
    else $error("pending result changed before it was taken");

  // in_ready is low in the cycle after an item is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting an item");

  // a point is not finished while one of its earlier coordinates is pending
  a_no_ready_mid_point: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("ready while a non-final coordinate is pending");

endmodule

bind halton_point_generator_top hpg_props #(
  .INDEX_BITS(INDEX_BITS),
  .COORD_BITS(COORD_BITS)
) u_hpg_props (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .point_index(point_index),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .coordinate (coordinate),
  .dim_index  (dim_index),
  .last       (last)
);
